// File: sv/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Shared concurrent assertion macros for the landmark association checks.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: sv/gpla_pkg.sv
// ============================================================================
// gpla_pkg
// Types, widths and codes shared by the plane landmark association modules.
// ============================================================================
`default_nettype none

package gpla_pkg;

    localparam int MAX_LANDMARKS = 64;
    localparam int IDX_W         = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int CNT_W         = $clog2(MAX_LANDMARKS + 1);

    localparam int NORM_W     = 16;
    localparam int OFS_W      = 24;
    localparam int HITS_W     = 16;
    localparam int COS_W      = 15;
    localparam int TOL_W      = 23;
    localparam int OUT_IDX_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int ENTRY_W    = 3 * NORM_W + OFS_W + HITS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_COS_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TOLERANCE = 2'd1;

    localparam logic [COS_W-1:0]  COS_RESET = 15'd32269;
    localparam logic [TOL_W-1:0]  TOL_RESET = 23'd6554;
    localparam logic [HITS_W-1:0] HITS_MAX  = 16'hFFFF;

    typedef logic signed [NORM_W-1:0] norm_t;
    typedef logic signed [OFS_W-1:0]  ofs_t;
    typedef logic [HITS_W-1:0]        hits_t;

    typedef struct packed {
        norm_t nx;
        norm_t ny;
        norm_t nz;
        ofs_t  ofs;
        hits_t hits;
    } entry_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] index;
        logic                 created;
        logic                 table_full;
        hits_t                count;
    } result_t;

    typedef struct packed {
        logic   start;
        norm_t  in_nx;
        norm_t  in_ny;
        norm_t  in_nz;
        ofs_t   in_ofs;
        entry_t lm;
    } upd_req_t;

    typedef struct packed {
        logic  done;
        norm_t nx;
        norm_t ny;
        norm_t nz;
        ofs_t  ofs;
    } upd_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_UPDATE,
        ST_RESULT
    } ctl_state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_SQRT,
        U_DSET,
        U_DIV,
        U_DSTORE,
        U_DONE
    } upd_state_t;

endpackage

`default_nettype wire

// File: sv/gpla_ram.sv
// ============================================================================
// gpla_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
`default_nettype none

module gpla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/gpla_update.sv
// ============================================================================
// gpla_update
// Running-mean update of one landmark: weighted normal sum, renormalization
// through an integer square root and rounded divisions, and offset averaging.
// ============================================================================
`default_nettype none

module gpla_update import gpla_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  upd_req_t req,
    output upd_rsp_t rsp
);

    localparam logic [1:0] K_OFFSET = 2'd3;
    localparam int NORM_QB = 17;
    localparam int OFS_QB  = 24;

    upd_state_t state_reg, state_next;

    logic [2:0] step_reg;
    logic [4:0] cnt_reg;
    logic [1:0] k_reg;

    norm_t in_nx_reg, in_ny_reg, in_nz_reg;
    ofs_t  in_d_reg;
    norm_t lm_nx_reg, lm_ny_reg, lm_nz_reg;
    ofs_t  lm_d_reg;
    hits_t m_reg;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p_reg;
    logic signed [31:0] sx_reg, sy_reg, sz_reg;
    logic signed [40:0] num_reg;
    logic [63:0] sq_reg, v_reg, root_reg;
    logic [63:0] sqrt_bit, sqrt_trial;

    logic [49:0] rem_reg, dsh_reg;
    logic [23:0] q_reg;
    logic        neg_reg;
    logic        ge;

    norm_t nx_reg, ny_reg, nz_reg;
    ofs_t  d_new_reg;

    logic signed [31:0] s_sel;
    logic [31:0] s_mag;
    logic [39:0] num_mag;
    logic [16:0] den;
    logic [31:0] root_lo;
    logic        r_zero;
    norm_t       norm_q;
    ofs_t        ofs_q;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            3'd0: begin
                mul_a = 32'(lm_nx_reg);
                mul_b = $signed({16'b0, m_reg});
            end
            3'd1: begin
                mul_a = 32'(lm_ny_reg);
                mul_b = $signed({16'b0, m_reg});
            end
            3'd2: begin
                mul_a = 32'(lm_nz_reg);
                mul_b = $signed({16'b0, m_reg});
            end
            3'd3: begin
                mul_a = 32'(lm_d_reg);
                mul_b = $signed({16'b0, m_reg});
            end
            3'd4: begin
                mul_a = sx_reg;
                mul_b = sx_reg;
            end
            3'd5: begin
                mul_a = sy_reg;
                mul_b = sy_reg;
            end
            3'd6: begin
                mul_a = sz_reg;
                mul_b = sz_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        sqrt_bit   = 64'd1 << {cnt_reg, 1'b0};
        sqrt_trial = root_reg + sqrt_bit;
        root_lo    = root_reg[31:0];
        r_zero     = (root_reg == '0);
        ge         = (rem_reg >= dsh_reg);
        den        = {1'b0, m_reg} + 17'd1;

        case (k_reg)
            2'd0:    s_sel = sx_reg;
            2'd1:    s_sel = sy_reg;
            default: s_sel = sz_reg;
        endcase
        s_mag   = s_sel[31] ? 32'(-s_sel) : 32'(s_sel);
        num_mag = num_reg[40] ? 40'(-num_reg) : 40'(num_reg);

        if (neg_reg) begin
            norm_q = ~q_reg[15:0] + 16'd1;
        end else if (|q_reg[23:15]) begin
            norm_q = 16'h7FFF;
        end else begin
            norm_q = q_reg[15:0];
        end

        if (neg_reg) begin
            ofs_q = (q_reg > 24'h800000) ? 24'h800000 : (~q_reg + 24'd1);
        end else begin
            ofs_q = q_reg[23] ? 24'h7FFFFF : q_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    state_next = U_MUL;
                end
            end
            U_MUL: begin
                if (step_reg == 3'd7) begin
                    state_next = U_SQRT;
                end
            end
            U_SQRT: begin
                if (cnt_reg == '0) begin
                    state_next = U_DSET;
                end
            end
            U_DSET: begin
                if (k_reg == K_OFFSET || !r_zero) begin
                    state_next = U_DIV;
                end
            end
            U_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = U_DSTORE;
                end
            end
            U_DSTORE: begin
                state_next = (k_reg == K_OFFSET) ? U_DONE : U_DSET;
            end
            U_DONE: begin
                state_next = U_IDLE;
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    in_nx_reg <= req.in_nx;
                    in_ny_reg <= req.in_ny;
                    in_nz_reg <= req.in_nz;
                    in_d_reg  <= req.in_ofs;
                    lm_nx_reg <= req.lm.nx;
                    lm_ny_reg <= req.lm.ny;
                    lm_nz_reg <= req.lm.nz;
                    lm_d_reg  <= req.lm.ofs;
                    m_reg     <= req.lm.hits;
                    step_reg  <= '0;
                end
            end
            U_MUL: begin
                mul_p_reg <= mul_a * mul_b;
                step_reg  <= step_reg + 3'd1;
                case (step_reg)
                    3'd1: sx_reg <= mul_p_reg[31:0] + 32'(in_nx_reg);
                    3'd2: sy_reg <= mul_p_reg[31:0] + 32'(in_ny_reg);
                    3'd3: sz_reg <= mul_p_reg[31:0] + 32'(in_nz_reg);
                    3'd4: num_reg <= mul_p_reg[40:0] + 41'(in_d_reg);
                    3'd5: sq_reg <= 64'(mul_p_reg);
                    3'd6: sq_reg <= sq_reg + 64'(mul_p_reg);
                    3'd7: begin
                        v_reg    <= sq_reg + 64'(mul_p_reg);
                        root_reg <= '0;
                        cnt_reg  <= 5'd31;
                        k_reg    <= '0;
                    end
                    default: ;
                endcase
            end
            U_SQRT: begin
                if (v_reg >= sqrt_trial) begin
                    v_reg    <= v_reg - sqrt_trial;
                    root_reg <= (root_reg >> 1) + sqrt_bit;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            U_DSET: begin
                q_reg <= '0;
                if (k_reg == K_OFFSET) begin
                    neg_reg <= num_reg[40];
                    rem_reg <= 50'({num_mag, 1'b0}) + 50'(den);
                    dsh_reg <= 50'(den) << OFS_QB;
                    cnt_reg <= 5'(OFS_QB - 1);
                end else if (r_zero) begin
                    case (k_reg)
                        2'd0:    nx_reg <= '0;
                        2'd1:    ny_reg <= '0;
                        default: nz_reg <= '0;
                    endcase
                    k_reg <= k_reg + 2'd1;
                end else begin
                    neg_reg <= s_sel[31];
                    rem_reg <= 50'({s_mag, 16'b0}) + 50'(root_lo);
                    dsh_reg <= 50'(root_lo) << NORM_QB;
                    cnt_reg <= 5'(NORM_QB - 1);
                end
            end
            U_DIV: begin
                if (ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg   <= {q_reg[22:0], ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 5'd1;
            end
            U_DSTORE: begin
                case (k_reg)
                    2'd0:    nx_reg <= norm_q;
                    2'd1:    ny_reg <= norm_q;
                    2'd2:    nz_reg <= norm_q;
                    default: d_new_reg <= ofs_q;
                endcase
                k_reg <= k_reg + 2'd1;
            end
            default: ;
        endcase
    end

    assign rsp = '{done: (state_reg == U_DONE), nx: nx_reg, ny: ny_reg, nz: nz_reg,
                   ofs: d_new_reg};

endmodule

`default_nettype wire

// File: sv/greedy_plane_landmark_association.sv
// ============================================================================
// greedy_plane_landmark_association
// Associates plane detections with a table of plane landmarks and folds each
// match into its landmark as a count-weighted running mean.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    normal x/y/z, plane offset
//   m_        out        m_valid/m_ready    index, created, full, count
//   cfg_      in         cfg_wr_en          register index and data
//
// A request without a match scans the N landmarks in use, reading the
// table memory one entry per cycle through a two-stage compare pipeline.
// A match adds a pass through the update unit: a 32-step square root and
// up to four bit-serial rounded divisions. One request is in flight at a
// time; a finished result waits in the output register while the next
// request is accepted. Reset empties the table.
// ============================================================================
`default_nettype none

module greedy_plane_landmark_association import gpla_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [15:0]    s_normal_x,
    input  logic signed [15:0]    s_normal_y,
    input  logic signed [15:0]    s_normal_z,
    input  logic signed [23:0]    s_plane_offset,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [5:0]            m_landmark_index,
    output logic                  m_created,
    output logic                  m_table_full,
    output logic [15:0]           m_observation_count
);

    ctl_state_t state_reg, state_next;

    logic [COS_W-1:0] cos_thr_reg;
    logic [TOL_W-1:0] tol_reg;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] iss_reg;

    norm_t in_nx_reg, in_ny_reg, in_nz_reg;
    ofs_t  in_d_reg;

    logic             rd_vld_reg, st1_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg, st1_idx_reg;
    logic signed [31:0] p0_reg, p1_reg, p2_reg;
    logic [24:0]      diff_reg;

    logic               found_reg;
    logic signed [33:0] best_dot_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    hits_t              hits_reg;
    hits_t              hits_new;

    result_t res_reg, res_next;
    result_t out_reg;
    logic    m_valid_reg;

    logic             accept;
    logic             issuing;
    logic             scan_done;
    logic             used_inc;
    logic             out_load;
    logic             upd_start;
    logic signed [24:0] d_sub;
    logic signed [33:0] dot;
    logic signed [33:0] thr;
    logic             cand;
    logic             take_best;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t           rd_entry;

    upd_req_t upd_req;
    upd_rsp_t upd_rsp;

    gpla_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LANDMARKS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    gpla_update u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (upd_req),
        .rsp     (upd_rsp)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign issuing   = (state_reg == ST_SCAN) && (iss_reg < used_reg);
    assign scan_done = (state_reg == ST_SCAN) && !issuing && !rd_vld_reg && !st1_vld_reg;
    assign ram_raddr = issuing ? iss_reg[IDX_W-1:0] : best_idx_reg;

    assign d_sub     = 25'(in_d_reg) - 25'(rd_entry.ofs);
    assign dot       = 34'(p0_reg) + 34'(p1_reg) + 34'(p2_reg);
    assign thr       = $signed({4'b0, cos_thr_reg, 15'b0});
    assign cand      = st1_vld_reg && (dot >= thr) && (diff_reg <= 25'(tol_reg));
    assign take_best = cand && (!found_reg || dot > best_dot_reg);
    assign hits_new  = (hits_reg == HITS_MAX) ? hits_reg : hits_reg + 16'd1;

    assign upd_req = '{start: upd_start, in_nx: in_nx_reg, in_ny: in_ny_reg,
                       in_nz: in_nz_reg, in_ofs: in_d_reg, lm: rd_entry};

    always_comb begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = used_reg[IDX_W-1:0];
        ram_wdata  = '0;
        res_next   = res_reg;
        used_inc   = 1'b0;
        upd_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    if (found_reg) begin
                        state_next = ST_FETCH;
                    end else if (used_reg < CNT_W'(MAX_LANDMARKS)) begin
                        ram_we     = 1'b1;
                        ram_wdata  = '{nx: in_nx_reg, ny: in_ny_reg, nz: in_nz_reg,
                                       ofs: in_d_reg, hits: 16'd1};
                        used_inc   = 1'b1;
                        res_next   = '{index: OUT_IDX_W'(used_reg), created: 1'b1,
                                       table_full: 1'b0, count: 16'd1};
                        state_next = ST_RESULT;
                    end else begin
                        res_next   = '{index: '0, created: 1'b0, table_full: 1'b1,
                                       count: '0};
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_FETCH: begin
                upd_start  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                ram_waddr = best_idx_reg;
                if (upd_rsp.done) begin
                    ram_we     = 1'b1;
                    ram_wdata  = '{nx: upd_rsp.nx, ny: upd_rsp.ny, nz: upd_rsp.nz,
                                   ofs: upd_rsp.ofs, hits: hits_new};
                    res_next   = '{index: OUT_IDX_W'(best_idx_reg), created: 1'b0,
                                   table_full: 1'b0, count: hits_new};
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cos_thr_reg <= COS_RESET;
            tol_reg     <= TOL_RESET;
            used_reg    <= '0;
            iss_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            st1_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_COS_THRESHOLD:    cos_thr_reg <= cfg_data[COS_W-1:0];
                    CFG_OFFSET_TOLERANCE: tol_reg <= cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            if (used_inc) begin
                used_reg <= used_reg + 1'b1;
            end
            if (accept) begin
                iss_reg <= '0;
            end else if (issuing) begin
                iss_reg <= iss_reg + 1'b1;
            end
            rd_vld_reg  <= issuing;
            st1_vld_reg <= rd_vld_reg;
            if (accept) begin
                found_reg <= 1'b0;
            end else if (take_best) begin
                found_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_nx_reg <= s_normal_x;
            in_ny_reg <= s_normal_y;
            in_nz_reg <= s_normal_z;
            in_d_reg  <= s_plane_offset;
        end
        rd_idx_reg  <= iss_reg[IDX_W-1:0];
        st1_idx_reg <= rd_idx_reg;
        p0_reg      <= in_nx_reg * rd_entry.nx;
        p1_reg      <= in_ny_reg * rd_entry.ny;
        p2_reg      <= in_nz_reg * rd_entry.nz;
        diff_reg    <= d_sub[24] ? 25'(-d_sub) : 25'(d_sub);
        if (take_best) begin
            best_dot_reg <= dot;
            best_idx_reg <= st1_idx_reg;
        end
        if (state_reg == ST_FETCH) begin
            hits_reg <= rd_entry.hits;
        end
        res_reg <= res_next;
        if (out_load) begin
            out_reg <= res_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_landmark_index    = out_reg.index;
    assign m_created           = out_reg.created;
    assign m_table_full        = out_reg.table_full;
    assign m_observation_count = out_reg.count;

endmodule

`default_nettype wire

// File: sv/gpla_checker.sv
// ============================================================================
// gpla_checker
// Port-level checks on the result channel of the landmark association block.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module gpla_checker import gpla_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic signed [15:0]    s_normal_x,
    input logic signed [15:0]    s_normal_y,
    input logic signed [15:0]    s_normal_z,
    input logic signed [23:0]    s_plane_offset,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [5:0]            m_landmark_index,
    input logic                  m_created,
    input logic                  m_table_full,
    input logic [15:0]           m_observation_count
);

    // A stalled result holds its value.
    `ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_landmark_index) && $stable(m_observation_count) && $stable(m_created) && $stable(m_table_full))

    // A dropped detection is never also a new landmark.
    `ASSERT_IMPLIES(a_full_not_created, aclk, aresetn, m_valid && m_table_full, !m_created)

    // A dropped detection reports index and count as zero.
    `ASSERT_IMPLIES(a_full_zero, aclk, aresetn, m_valid && m_table_full, m_landmark_index == '0 && m_observation_count == '0)

    // A new landmark holds exactly one observation.
    `ASSERT_IMPLIES(a_created_one, aclk, aresetn, m_valid && m_created, m_observation_count == 16'd1)

    // A joined or created landmark always holds at least one observation.
    `ASSERT_IMPLIES(a_count_nonzero, aclk, aresetn, m_valid && !m_table_full, m_observation_count != '0)

endmodule

bind greedy_plane_landmark_association gpla_checker u_gpla_checker (.*);

`default_nettype wire

// File: tb/sv/tb_greedy_plane_landmark_association.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_greedy_plane_landmark_association
// Self-checking testbench for the plane landmark association block. A
// scoreboard class keeps its own landmark table, scores every accepted
// detection against it and queues the outcome it predicts. Each result that
// leaves the block is compared field by field with the oldest queued outcome.
// A short directed sequence covers the field extremes, tie breaking, an
// exactly zero summed normal and out-of-range register writes. Several random
// segments follow. Most random detections are jittered copies of landmarks
// already held, so matches, running means and a full table all occur. The
// segments use different register settings and idle patterns.
// ============================================================================

import gpla_pkg::*;

function automatic longint saturate(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
endfunction

class landmark_tracker;
    logic [COS_W-1:0] cos_thr;
    logic [TOL_W-1:0] ofs_tol;
    norm_t            lm_norm[MAX_LANDMARKS][3];
    ofs_t             lm_ofs[MAX_LANDMARKS];
    hits_t            lm_hits[MAX_LANDMARKS];
    int               used;
    result_t          outcomes_due[$];
    int               errors;

    function new();
        cos_thr = COS_RESET;
        ofs_tol = TOL_RESET;
        used    = 0;
        errors  = 0;
        for (int i = 0; i < MAX_LANDMARKS; i++) begin
            for (int k = 0; k < 3; k++) begin
                lm_norm[i][k] = '0;
            end
            lm_ofs[i]  = '0;
            lm_hits[i] = '0;
        end
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_COS_THRESHOLD: begin
                cos_thr = data[COS_W-1:0];
            end
            CFG_OFFSET_TOLERANCE: begin
                ofs_tol = data[TOL_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Rounds to nearest with ties away from zero; den is positive.
    static function longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function void note_detection(norm_t nx, norm_t ny, norm_t nz, ofs_t d);
        longint           nin[3];
        longint           sum[3];
        longint           thr, dot, diff, best_dot, m, mag;
        longint unsigned  sq, root, rem, bitv;
        int               best;
        bit               found;
        result_t          res;
        nin[0]   = nx;
        nin[1]   = ny;
        nin[2]   = nz;
        thr      = longint'(cos_thr) << 15;
        best_dot = 0;
        best     = 0;
        found    = 1'b0;
        for (int i = 0; i < used; i++) begin
            dot = nin[0] * lm_norm[i][0] + nin[1] * lm_norm[i][1] + nin[2] * lm_norm[i][2];
            diff = longint'(d) - longint'(lm_ofs[i]);
            if (diff < 0) begin
                diff = -diff;
            end
            if (dot >= thr && diff <= longint'(ofs_tol) && (!found || dot > best_dot)) begin
                found    = 1'b1;
                best_dot = dot;
                best     = i;
            end
        end
        res = '0;
        if (found) begin
            m  = longint'(lm_hits[best]);
            sq = 0;
            for (int k = 0; k < 3; k++) begin
                sum[k] = longint'(lm_norm[best][k]) * m + nin[k];
                mag    = (sum[k] < 0) ? -sum[k] : sum[k];
                sq    += longint'(mag * mag);
            end
            root = 0;
            rem  = sq;
            bitv = 64'h4000_0000_0000_0000;
            while (bitv > rem) begin
                bitv >>= 2;
            end
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem  -= root + bitv;
                    root  = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            for (int k = 0; k < 3; k++) begin
                lm_norm[best][k] = (root == 0) ? '0 : norm_t'(saturate(
                    round_div(sum[k] * 32768, longint'(root)), -32768, 32767));
            end
            lm_ofs[best] = ofs_t'(saturate(round_div(longint'(lm_ofs[best]) * m
                + longint'(d), m + 1), -8388608, 8388607));
            if (lm_hits[best] != HITS_MAX) begin
                lm_hits[best]++;
            end
            res.index = OUT_IDX_W'(best);
            res.count = lm_hits[best];
        end else if (used < MAX_LANDMARKS) begin
            lm_norm[used][0] = nx;
            lm_norm[used][1] = ny;
            lm_norm[used][2] = nz;
            lm_ofs[used]     = d;
            lm_hits[used]    = 1;
            res.index        = OUT_IDX_W'(used);
            res.created      = 1'b1;
            res.count        = 1;
            used++;
        end else begin
            res.table_full = 1'b1;
        end
        outcomes_due.push_back(res);
    endfunction

    function void check_outcome(result_t got);
        result_t want;
        if (outcomes_due.size() == 0) begin
            $error("result with no request outstanding: landmark_index %0d", got.index);
            errors++;
            return;
        end
        want = outcomes_due.pop_front();
        if (got.index !== want.index) begin
            $error("landmark_index: expected %0d, got %0d", want.index, got.index);
            errors++;
        end
        if (got.created !== want.created) begin
            $error("created: expected %0d, got %0d", want.created, got.created);
            errors++;
        end
        if (got.table_full !== want.table_full) begin
            $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
            errors++;
        end
        if (got.count !== want.count) begin
            $error("observation_count: expected %0d, got %0d", want.count, got.count);
            errors++;
        end
    endfunction

    function int pending();
        return outcomes_due.size();
    endfunction
endclass

module tb_greedy_plane_landmark_association;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    norm_t                 s_normal_x;
    norm_t                 s_normal_y;
    norm_t                 s_normal_z;
    ofs_t                  s_plane_offset;
    logic                  m_valid;
    logic                  m_ready;
    logic [5:0]            m_landmark_index;
    logic                  m_created;
    logic                  m_table_full;
    logic [15:0]           m_observation_count;

    int              tx_idle_pct;
    int              rx_idle_pct;
    landmark_tracker tracker;

    greedy_plane_landmark_association dut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_outcome({m_landmark_index, m_created, m_table_full,
                                   m_observation_count});
        end
    end

    function automatic int jitter(int amp);
        return int'($urandom_range(2 * amp)) - amp;
    endfunction

    task automatic send_detection(norm_t nx, norm_t ny, norm_t nz, ofs_t d);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_normal_x     <= nx;
        s_normal_y     <= ny;
        s_normal_z     <= nz;
        s_plane_offset <= d;
        do @(posedge aclk); while (!s_ready);
        tracker.note_detection(nx, ny, nz, d);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (tracker.pending() != 0);
    endtask

    task automatic configure(logic [COS_W-1:0] cos, logic [TOL_W-1:0] tol);
        logic [CFG_IDX_W-1:0]  spare;
        logic [CFG_DATA_W-1:0] data;
        data = {8'($urandom), cos};
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_COS_THRESHOLD;
        cfg_data  <= data;
        tracker.write_register(CFG_COS_THRESHOLD, data);
        @(negedge aclk);
        cfg_index <= CFG_OFFSET_TOLERANCE;
        cfg_data  <= tol;
        tracker.write_register(CFG_OFFSET_TOLERANCE, tol);
        @(negedge aclk);
        spare = $urandom_range(1) ? CFG_SPARE_B : CFG_SPARE_A;
        data  = CFG_DATA_W'($urandom);
        cfg_index <= spare;
        cfg_data  <= data;
        tracker.write_register(spare, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Mostly jittered copies of held landmarks, some fresh unit normals,
    // and some raw random bit patterns.
    task automatic make_detection(output norm_t nx, ny, nz, output ofs_t d);
        int  pick, amp, span, i;
        real fx, fy, fz, len;
        pick = $urandom_range(99);
        if (pick < 70 && tracker.used > 0) begin
            i    = $urandom_range(tracker.used - 1);
            amp  = ($urandom_range(3) == 0) ? 0 : $urandom_range(400);
            span = (tracker.ofs_tol > 200000) ? 200000 : tracker.ofs_tol + 8;
            nx = norm_t'(saturate(tracker.lm_norm[i][0] + jitter(amp), -32768, 32767));
            ny = norm_t'(saturate(tracker.lm_norm[i][1] + jitter(amp), -32768, 32767));
            nz = norm_t'(saturate(tracker.lm_norm[i][2] + jitter(amp), -32768, 32767));
            d  = ofs_t'(saturate(tracker.lm_ofs[i] + jitter(span), -8388608, 8388607));
        end else if (pick < 90) begin
            fx  = real'($urandom_range(65535)) - 32768.0;
            fy  = real'($urandom_range(65535)) - 32768.0;
            fz  = real'($urandom_range(65535)) - 32768.0;
            len = $sqrt(fx * fx + fy * fy + fz * fz);
            if (len < 1.0) begin
                fx  = 1.0;
                len = 1.0;
            end
            nx = norm_t'($rtoi(fx * 32767.0 / len));
            ny = norm_t'($rtoi(fy * 32767.0 / len));
            nz = norm_t'($rtoi(fz * 32767.0 / len));
            d  = $urandom_range(1) ? ofs_t'($urandom) : ofs_t'(jitter(100000));
        end else begin
            nx = norm_t'($urandom);
            ny = norm_t'($urandom);
            nz = norm_t'($urandom);
            d  = ofs_t'($urandom);
        end
    endtask

    task automatic run_random(int items, int tx_pct, int rx_pct,
                              logic [COS_W-1:0] cos, logic [TOL_W-1:0] tol);
        norm_t nx, ny, nz;
        ofs_t  d;
        wait_drained();
        configure(cos, tol);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (items) begin
            if ($urandom_range(99) == 0) begin
                wait_drained();
            end
            make_detection(nx, ny, nz, d);
            send_detection(nx, ny, nz, d);
        end
    endtask

    initial begin
        tracker        = new();
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_COS_THRESHOLD;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_normal_x     = '0;
        s_normal_y     = '0;
        s_normal_z     = '0;
        s_plane_offset = '0;
        m_ready        = 1'b0;
        tx_idle_pct    = 10;
        rx_idle_pct    = 85;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Registers still hold their reset values here.
        send_detection(32767, 0, 0, 0);
        send_detection(32767, 0, 0, 0);
        send_detection(32767, 0, 0, 6554);
        send_detection(32767, 0, 0, 8740);
        send_detection(-32768, 0, 0, -8388608);
        send_detection(0, 32767, 0, 8388607);
        send_detection(0, 0, -32768, 0);
        send_detection(0, 0, 0, -5000000);
        // Two equal normals with offsets apart, then a request between them:
        // the dot products tie and the lower index has to win.
        send_detection(0, 23170, 23170, 100000);
        send_detection(0, 23170, 23170, 110000);
        send_detection(0, 23170, 23170, 105000);
        // Here the later landmark has the larger dot product and has to win.
        send_detection(32767, 0, 0, 2000000);
        send_detection(32700, 2093, 0, 2010000);
        send_detection(32700, 2093, 0, 2005000);
        send_detection(32767, 32767, 32767, 0);
        send_detection(-32768, -32768, -32768, -8388608);
        send_detection(-1, -1, -1, -1);
        send_detection(32767, -32768, 1, 8388607);

        // With a zero threshold and tolerance, a zero normal joins the zero
        // landmark and the summed normal is exactly zero.
        wait_drained();
        configure(0, 0);
        send_detection(0, 0, 0, -5000000);
        send_detection(0, 0, 0, -5000000);
        send_detection(-32768, 0, 0, 8740);
        send_detection(0, 1, 0, 8388607);

        run_random(155, 10, 85, COS_RESET, TOL_RESET);
        run_random(155, 10, 85, 15'd32767, 23'd8388607);
        run_random(155, 85, 10, 15'd0, 23'd8388607);
        run_random(155, 85, 10, 15'($urandom_range(32767, 28000)),
                   23'($urandom_range(50000)));
        run_random(155, 0, 0, 15'd0, 23'd0);
        run_random(155, 0, 0, 15'd31500, 23'd3000);

        wait_drained();
        repeat (250) @(negedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
